FILE: rtl/page_frame_allocator_refcount_top_assert.svh
// assertion macros used by the checker file
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_TOP_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PFA_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define PFA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int FRAME_W    = 16;
    localparam int REF_W      = 8;
    localparam int NUM_FRAMES = 65536;
    localparam int TOP_W      = $clog2(NUM_FRAMES) + 1;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;

    localparam logic [REF_W-1:0] REF_MAX = '1;
    localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(NUM_FRAMES);

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 3'd0,
        KIND_FREE  = 3'd1,
        KIND_INC   = 3'd2,
        KIND_DEC   = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_OOM   = 2'd1,
        STAT_BAD   = 2'd2,
        STAT_LIMIT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FRAME_W-1:0] frame;
    } req_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_out;
        logic [REF_W-1:0]    ref_count;
        logic [TOP_W-1:0]    free_count;
        logic [STATUS_W-1:0] status;
    } res_t;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic pop;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_stat_t;

endpackage

FILE: rtl/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// sequencer: table clear after reset, then request read, pop for allocate, and execute
// ----------------------------------------------------------------------------
module pfa_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pfa_pkg::KIND_W-1:0]      req_kind,
    input  pfa_pkg::dp_stat_t               stat,
    output pfa_pkg::dp_cmd_t                cmd,
    output logic                            busy,
    output logic                            done
);
    import pfa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = (req_kind == KIND_ALLOC) ? ST_POP : ST_EXEC;
            end
            ST_POP:  state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        busy      = 1'b1;
        done_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_en = 1'b1;
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_POP:   cmd.pop = 1'b1;
            ST_EXEC:
            begin
                cmd.exec  = 1'b1;
                done_next = 1'b1;
            end
            default:  busy = 1'b1;
        endcase
    end

    assign done = done_reg;

endmodule

FILE: rtl/pfa_dpath.sv
// ----------------------------------------------------------------------------
// pfa_dpath
// free stack, reference table, counters and result register
// ----------------------------------------------------------------------------
module pfa_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pfa_pkg::dp_cmd_t                cmd,
    output pfa_pkg::dp_stat_t               stat,
    input  pfa_pkg::req_t                   req,
    input  logic                            cfg_we,
    input  logic [pfa_pkg::FRAME_W-1:0]     cfg_data,
    output pfa_pkg::res_t                   result
);
    import pfa_pkg::*;

    logic [FRAME_W-1:0] stack_mem [NUM_FRAMES];
    logic [REF_W-1:0]   ref_mem   [NUM_FRAMES];

    logic [FRAME_W-1:0] clr_addr_reg;
    logic [FRAME_W-1:0] first_usable_reg;
    logic [TOP_W-1:0]   stack_top_reg;
    logic [TOP_W-1:0]   stack_top_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] gframe_reg;
    logic [FRAME_W-1:0] stack_rd_reg;
    logic [REF_W-1:0]   ref_rd_reg;
    res_t               result_reg;
    res_t               result_next;

    logic [FRAME_W-1:0] stack_rd_addr;
    logic [FRAME_W-1:0] ref_rd_addr;
    logic [FRAME_W-1:0] act_frame;
    logic [REF_W-1:0]   new_cnt;
    logic [REF_W-1:0]   dec_cnt;
    logic               is_alloc;
    logic               empty;
    logic               bad;
    logic               at_max;
    logic               zero;
    logic               ref_we;
    logic               push;
    logic               pop_top;
    logic [STATUS_W-1:0] st;

    assign stat.clear_last = (clr_addr_reg == '1);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            first_usable_reg <= '0;
            stack_top_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_en)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (cfg_we)
                first_usable_reg <= cfg_data;
            if (cmd.exec)
                stack_top_reg <= stack_top_next;
        end
    end

    // request payload, pop result and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= req.kind;
            frame_reg <= req.frame;
        end
        if (cmd.pop)
            gframe_reg <= stack_rd_reg;
        if (cmd.exec)
            result_reg <= result_next;
    end

    assign stack_rd_addr = stack_top_reg[FRAME_W-1:0] - 1'b1;
    assign ref_rd_addr   = cmd.pop ? stack_rd_reg : req.frame;

    // free stack
    always_ff @(posedge clk)
    begin
        stack_rd_reg <= stack_mem[stack_rd_addr];
        if (cmd.exec && push)
            stack_mem[stack_top_reg[FRAME_W-1:0]] <= frame_reg;
    end

    // reference table
    always_ff @(posedge clk)
    begin
        ref_rd_reg <= ref_mem[ref_rd_addr];
        if (cmd.clear_en)
            ref_mem[clr_addr_reg] <= '0;
        else if (cmd.exec && ref_we)
            ref_mem[act_frame] <= new_cnt;
    end

    assign is_alloc  = (kind_reg == KIND_ALLOC);
    assign act_frame = is_alloc ? gframe_reg : frame_reg;
    assign empty     = (stack_top_reg == '0);
    assign bad       = !is_alloc && (frame_reg < first_usable_reg);
    assign at_max    = (ref_rd_reg == REF_MAX);
    assign zero      = (ref_rd_reg == '0);
    assign dec_cnt   = zero ? '0 : ref_rd_reg - 1'b1;

    always_comb
    begin
        new_cnt = ref_rd_reg;
        ref_we  = 1'b0;
        push    = 1'b0;
        pop_top = 1'b0;
        st      = STAT_OK;
        if (bad)
            st = STAT_BAD;
        else
        begin
            case (kind_reg)
                KIND_ALLOC:
                begin
                    if (empty)
                        st = STAT_OOM;
                    else
                    begin
                        pop_top = 1'b1;
                        ref_we  = 1'b1;
                        if (at_max)
                            st = STAT_LIMIT;
                        else
                            new_cnt = ref_rd_reg + 1'b1;
                    end
                end
                KIND_FREE:
                begin
                    ref_we  = 1'b1;
                    new_cnt = dec_cnt;
                    if (dec_cnt == '0)
                    begin
                        if (stack_top_reg == TOP_FULL)
                            st = STAT_LIMIT;
                        else
                            push = 1'b1;
                    end
                end
                KIND_INC:
                begin
                    ref_we = 1'b1;
                    if (at_max)
                        st = STAT_LIMIT;
                    else
                        new_cnt = ref_rd_reg + 1'b1;
                end
                KIND_DEC:
                begin
                    ref_we  = 1'b1;
                    new_cnt = dec_cnt;
                    if (zero)
                        st = STAT_LIMIT;
                end
                default:
                begin
                    ref_we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (pop_top)
            stack_top_next = stack_top_reg - 1'b1;
        else if (push)
            stack_top_next = stack_top_reg + 1'b1;
        else
            stack_top_next = stack_top_reg;
    end

    // free count always tracks the stack depth
    always_comb
    begin
        result_next.frame_out  = (st == STAT_OOM) ? '0 : act_frame;
        result_next.ref_count  = (st == STAT_OOM || st == STAT_BAD) ? '0 : new_cnt;
        result_next.free_count = stack_top_next;
        result_next.status     = st;
    end

    assign result = result_reg;

endmodule

FILE: rtl/page_frame_allocator_refcount_top.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_top
// page frame allocator with free stack and saturating reference counts
// ----------------------------------------------------------------------------
// sequencing: free, increment, decrement and read go from idle straight to
//   execute, where done is registered; allocate passes a pop state first (stack pop, then reference-table read)
// requests: a new request is taken only in idle, with busy low, once the
//   previous request has executed
// reset: busy stays high while the reference table is
//   cleared one entry a cycle; the config register is writable throughout
// the receiver cannot stall: each result shows for one cycle with done
module page_frame_allocator_refcount_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  pfa_pkg::req_t                   req,
    // result channel
    output logic                            done,
    output pfa_pkg::res_t                   result,
    // config register: first usable frame
    input  logic                            cfg_we,
    input  logic [pfa_pkg::FRAME_W-1:0]     cfg_data
);
    import pfa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: clear pass, then idle / pop / execute per request
    pfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_kind (req.kind),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    // memories, stack pointer and result register
    pfa_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

FILE: rtl/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "page_frame_allocator_refcount_top_assert.svh"

module pfa_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           done,
    input  pfa_pkg::res_t  result
);
    import pfa_pkg::*;

    // a result only follows a busy cycle
    `PFA_ASSERT_IMPL(a_done_after_busy, clk, rst_n, done, $past(busy))
    // an accepted request makes the block busy
    `PFA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // results are single-cycle strobes, never back to back
    `PFA_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    // out of memory reports an empty stack and no frame
    `PFA_ASSERT_IMPL(a_oom_empty, clk, rst_n, done && (result.status == STAT_OOM),
        (result.free_count == '0) && (result.frame_out == '0))
    // a bad frame reports a zero count
    `PFA_ASSERT_IMPL(a_bad_zero, clk, rst_n, done && (result.status == STAT_BAD),
        result.ref_count == '0)

endmodule

bind page_frame_allocator_refcount_top pfa_checker u_pfa_checker (.*);
